/* hdl/heightmap_bilinear_sampler_top_macros.svh */
// Assertion shorthands for the sampler checker.
`ifndef HEIGHTMAP_BILINEAR_SAMPLER_TOP_MACROS_SVH
`define HEIGHTMAP_BILINEAR_SAMPLER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define HBS_ASSERT_NOW(label, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error("sampler check failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define HBS_ASSERT_NEXT(label, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error("sampler check failed");

`endif

/* hdl/hbs_pkg.sv */
package hbs_pkg;

  localparam int GRID_SIZE_DEF = 256;
  // widest store address over the legal grid sizes (1024 x 1024)
  localparam int ADDR_MAX_W = 20;

  localparam logic [23:0] RECIP_RESET = 24'd65536;
  localparam logic [30:0] HALF_RESET  = 31'd8388608;

  // register select, taken from paddr[2]
  localparam logic REG_RECIP = 1'b0;
  localparam logic REG_HALF  = 1'b1;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_MISS,
    OP_SAMPLE
  } op_t;

  typedef struct packed {
    logic               kind;
    logic [15:0]        write_index;
    logic [15:0]        write_height;
    logic signed [31:0] query_x;
    logic signed [31:0] query_y;
  } item_t;

  typedef struct packed {
    logic [15:0] height;
    logic        in_range;
  } result_t;

  typedef struct packed {
    logic [23:0] grid_step_recip;
    logic [30:0] half_extent;
  } cfg_t;

  // classified work: store address (write target or sample base), write data, weights
  typedef struct packed {
    op_t                   op;
    logic [ADDR_MAX_W-1:0] addr;
    logic [15:0]           data;
    logic [15:0]           fx;
    logic [15:0]           fy;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } job_req_t;

endpackage

/* hdl/heightmap_bilinear_sampler_top.sv */
// Heightmap bilinear sampler.
// Items enter on item_valid/item_stall; a transfer happens on a clock edge with valid high and
// stall low. kind selects a grid write (write_index, write_height) or a query (query_x,
// query_y, signed Q16.16). Each query gives one transfer on result_valid/result_stall; a
// write gives none, and a write past the end of the grid is dropped.
// Configuration sits on an APB-style port: grid_step_recip at 0x0, half_extent at 0x4.
// A query outside the grid goes through both front stages and the queue to the result register;
// a query inside the grid also goes through the corner reads and the multiplier passes. Writes
// retire at dispatch, outside-grid queries at dispatch once the result register is free. A query
// inside the grid holds the back end while it is dispatched, makes the four corner reads through
// the store's single read port, six passes through the one shared multiplier, and hands off the
// result. The front end and a 4-entry queue keep taking items meanwhile.
// Reset clears the pipeline, the queue and the result register and restores the register
// defaults; the height store is not cleared and must be written before it is sampled.
// A stalled result holds in its register while the front end keeps filling the queue;
// item_stall rises once the queue and both front stages are full.
module heightmap_bilinear_sampler_top #(
  parameter int GRID_SIZE = hbs_pkg::GRID_SIZE_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  hbs_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output hbs_pkg::result_t result,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import hbs_pkg::*;

  cfg_t     cfg;
  logic     cfg_wr;
  job_req_t push;
  logic     push_ready;
  job_req_t head;
  logic     pop;

  // Register file: written on the access phase, word select on paddr[2]
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grid_step_recip <= RECIP_RESET;
      cfg.half_extent     <= HALF_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_RECIP: cfg.grid_step_recip <= pwdata[23:0];
        REG_HALF:  cfg.half_extent     <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_RECIP: prdata = {8'b0, cfg.grid_step_recip};
      REG_HALF:  prdata = {1'b0, cfg.half_extent};
      default:   prdata = '0;
    endcase
  end

  // Front end: register the item, scale both coordinates, classify
  hbs_front #(
    .GRID_SIZE(GRID_SIZE)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .push       (push),
    .push_ready (push_ready)
  );

  // Decouple classification from the store and the interpolator
  hbs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .head       (head),
    .pop        (pop)
  );

  // Back end: height store, corner fetch, blend, result register
  hbs_back #(
    .GRID_SIZE(GRID_SIZE)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

/* hdl/hbs_front.sv */
module hbs_front #(
  parameter int GRID_SIZE = hbs_pkg::GRID_SIZE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  hbs_pkg::cfg_t      cfg,
  input  logic               item_valid,
  output logic               item_stall,
  input  hbs_pkg::item_t     item,
  output hbs_pkg::job_req_t  push,
  input  logic               push_ready
);
  import hbs_pkg::*;

  localparam int IDXW  = $clog2(GRID_SIZE);
  localparam int CELLS = GRID_SIZE * GRID_SIZE;
  localparam int ADDRW = $clog2(CELLS);
  localparam logic [24:0] IDX_LAST = 25'(GRID_SIZE - 2);
  localparam logic [20:0] CELLS_W  = 21'(CELLS);

  logic               s1_valid;
  item_t              s1_item;
  logic               s2_valid;
  logic               s2_kind;
  logic [15:0]        s2_index;
  logic [15:0]        s2_wheight;
  logic signed [57:0] s2_px;
  logic signed [57:0] s2_py;

  logic               s1_ready;
  logic               s2_ready;
  logic               s2_keep;
  logic signed [32:0] sx;
  logic signed [32:0] sy;
  logic signed [57:0] px;
  logic signed [57:0] py;
  logic               x_ok;
  logic               y_ok;
  logic               wr_ok;
  logic [ADDRW-1:0]   base;
  job_t               job;

  // offset and scale; both products are exact
  assign sx = $signed({s1_item.query_x[31], s1_item.query_x}) + $signed({2'b00, cfg.half_extent});
  assign sy = $signed({s1_item.query_y[31], s1_item.query_y}) + $signed({2'b00, cfg.half_extent});
  assign px = sx * $signed({1'b0, cfg.grid_step_recip});
  assign py = sy * $signed({1'b0, cfg.grid_step_recip});

  // classify
  assign x_ok  = !s2_px[57] && (s2_px[56:32] <= IDX_LAST);
  assign y_ok  = !s2_py[57] && (s2_py[56:32] <= IDX_LAST);
  assign wr_ok = {5'b0, s2_index} < CELLS_W;
  assign base  = ADDRW'(s2_py[32 +: IDXW]) * ADDRW'(GRID_SIZE) + ADDRW'(s2_px[32 +: IDXW]);

  always_comb begin
    job.data = s2_wheight;
    job.fx   = s2_px[31:16];
    job.fy   = s2_py[31:16];
    if (s2_kind == KIND_WRITE) begin
      job.op   = OP_WRITE;
      job.addr = ADDR_MAX_W'(s2_index);
      s2_keep  = wr_ok;
    end else begin
      job.op   = (x_ok && y_ok) ? OP_SAMPLE : OP_MISS;
      job.addr = ADDR_MAX_W'(base);
      s2_keep  = 1'b1;
    end
  end

  assign push.valid = s2_valid && s2_keep;
  assign push.job   = job;

  // a write outside the grid drains without a push
  assign s2_ready   = !s2_valid || push_ready || !s2_keep;
  assign s1_ready   = !s1_valid || s2_ready;
  assign item_stall = !s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= item_valid;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && s1_ready) begin
      s1_item <= item;
    end
    if (s1_valid && s2_ready) begin
      s2_kind    <= s1_item.kind;
      s2_index   <= s1_item.write_index;
      s2_wheight <= s1_item.write_height;
      s2_px      <= px;
      s2_py      <= py;
    end
  end

endmodule

/* hdl/hbs_queue.sv */
module hbs_queue (
  input  logic              clk,
  input  logic              rst,
  input  hbs_pkg::job_req_t push,
  output logic              push_ready,
  output hbs_pkg::job_req_t head,
  input  logic              pop
);
  import hbs_pkg::*;

  localparam int DEPTH = 4;
  localparam int PTRW  = $clog2(DEPTH);

  job_t            slots [DEPTH];
  logic [PTRW-1:0] wr_ptr;
  logic [PTRW-1:0] rd_ptr;
  logic [PTRW:0]   count;
  logic            do_push;
  logic            do_pop;

  assign push_ready = count != (PTRW+1)'(DEPTH);
  assign head.valid = count != '0;
  assign head.job   = slots[rd_ptr];
  assign do_push    = push.valid && push_ready;
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push.job;
    end
  end

endmodule

/* hdl/hbs_back.sv */
module hbs_back #(
  parameter int GRID_SIZE = hbs_pkg::GRID_SIZE_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  hbs_pkg::job_req_t head,
  output logic              pop,
  output logic              result_valid,
  input  logic              result_stall,
  output hbs_pkg::result_t  result
);
  import hbs_pkg::*;

  localparam int CELLS = GRID_SIZE * GRID_SIZE;
  localparam int ADDRW = $clog2(CELLS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_MAC  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  localparam logic [2:0] READ_LAST = 3'd4;
  localparam logic [2:0] MAC_LAST  = 3'd6;

  logic [1:0]       state;
  logic [2:0]       step;
  job_t             job;
  logic [15:0]      corner [4];
  logic [15:0]      mem [CELLS];
  logic [15:0]      rd_data;
  logic [ADDRW-1:0] base;
  logic [ADDRW-1:0] rd_addr;
  logic             wr_en;
  logic             out_free;
  logic             res_load;
  result_t          res_next;
  logic             start;

  logic [31:0]      mul_a;
  logic [16:0]      mul_b;
  logic [48:0]      prod;
  logic [31:0]      lo;
  logic [31:0]      hi;
  logic [47:0]      v;
  logic [47:0]      rounded;
  logic [16:0]      wx0;
  logic [16:0]      wy0;

  assign base     = job.addr[ADDRW-1:0];
  assign out_free = !result_valid || !result_stall;
  assign wx0      = 17'h10000 - {1'b0, job.fx};
  assign wy0      = 17'h10000 - {1'b0, job.fy};
  assign rounded  = v + 48'h0000_8000_0000;

  // corner order: lower-left, lower-right, upper-left, upper-right
  always_comb begin
    unique case (step[1:0])
      2'd0: rd_addr = base;
      2'd1: rd_addr = base + ADDRW'(1);
      2'd2: rd_addr = base + ADDRW'(GRID_SIZE);
      2'd3: rd_addr = base + ADDRW'(GRID_SIZE + 1);
      default: rd_addr = base;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[head.job.addr[ADDRW-1:0]] <= head.job.data;
    end
    rd_data <= mem[rd_addr];
  end

  // dispatch from the queue head
  always_comb begin
    pop      = 1'b0;
    wr_en    = 1'b0;
    start    = 1'b0;
    res_load = 1'b0;
    res_next = '0;
    if (state == ST_IDLE && head.valid) begin
      unique case (head.job.op)
        OP_WRITE: begin
          pop   = 1'b1;
          wr_en = 1'b1;
        end
        OP_MISS: begin
          pop      = out_free;
          res_load = out_free;
        end
        OP_SAMPLE: begin
          pop   = 1'b1;
          start = 1'b1;
        end
        default: pop = 1'b1;
      endcase
    end else if (state == ST_DONE && out_free) begin
      res_load          = 1'b1;
      res_next.height   = rounded[47:32];
      res_next.in_range = 1'b1;
    end
  end

  // shared multiplier operand select
  always_comb begin
    unique case (step)
      3'd0: begin mul_a = {16'b0, corner[0]}; mul_b = wx0;             end
      3'd1: begin mul_a = {16'b0, corner[1]}; mul_b = {1'b0, job.fx};  end
      3'd2: begin mul_a = {16'b0, corner[2]}; mul_b = wx0;             end
      3'd3: begin mul_a = {16'b0, corner[3]}; mul_b = {1'b0, job.fx};  end
      3'd4: begin mul_a = lo;                 mul_b = wy0;             end
      3'd5: begin mul_a = hi;                 mul_b = {1'b0, job.fy};  end
      default: begin mul_a = '0;              mul_b = '0;              end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_READ;
            step  <= '0;
          end
        end
        ST_READ: begin
          if (step == READ_LAST) begin
            state <= ST_MAC;
            step  <= '0;
          end else begin
            step <= step + 1'b1;
          end
        end
        ST_MAC: begin
          if (step == MAC_LAST) begin
            state <= ST_DONE;
            step  <= '0;
          end else begin
            step <= step + 1'b1;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath: corner capture, product register, accumulate from the registered product
  always_ff @(posedge clk) begin
    if (start) begin
      job <= head.job;
    end
    if (state == ST_READ && step != 3'd0) begin
      corner[2'(step - 3'd1)] <= rd_data;
    end
    if (state == ST_MAC) begin
      prod <= 49'(mul_a) * 49'(mul_b);
      unique case (step)
        3'd1: lo <= prod[31:0];
        3'd2: lo <= lo + prod[31:0];
        3'd3: hi <= prod[31:0];
        3'd4: hi <= hi + prod[31:0];
        3'd5: v  <= prod[47:0];
        3'd6: v  <= v + prod[47:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      result <= res_next;
    end
  end

endmodule

/* hdl/hbs_checker.sv */
`include "heightmap_bilinear_sampler_top_macros.svh"

module hbs_checker (
  input logic             clk,
  input logic             rst,
  input logic             item_valid,
  input logic             item_stall,
  input hbs_pkg::item_t   item,
  input logic             result_valid,
  input logic             result_stall,
  input hbs_pkg::result_t result
);
  import hbs_pkg::*;

  logic [3:0] pending;
  logic       query_in;
  logic       result_out;

  assign query_in   = item_valid && !item_stall && item.kind == KIND_QUERY;
  assign result_out = result_valid && !result_stall;

  // queries taken but not yet answered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (query_in && !result_out) begin
      pending <= pending + 1'b1;
    end else if (result_out && !query_in) begin
      pending <= pending - 1'b1;
    end
  end

  `HBS_ASSERT_NOW(a_result_owed, result_valid, pending != 4'd0)
  `HBS_ASSERT_NOW(a_miss_zero, result_valid && !result.in_range, result.height == 16'd0)
  `HBS_ASSERT_NOW(a_reset_quiet, $past(rst), !result_valid)
  `HBS_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result))

endmodule

bind heightmap_bilinear_sampler_top hbs_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .item         (item),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
